FILE: hdl/round_robin_job_dispatcher_assert.svh
// Assertion macros for the round-robin job dispatcher.
// Used by the executor module; relies on clk_i and rst_ni in scope.
`ifndef ROUND_ROBIN_JOB_DISPATCHER_ASSERT_SVH
`define ROUND_ROBIN_JOB_DISPATCHER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RRJD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define RRJD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rrjd_pkg.sv
// Shared types and constants for the round-robin job dispatcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rrjd_pkg;

  localparam int TAG_W         = 16;
  localparam int CORE_IDX_W    = 5;
  localparam int TCORE_W       = 4;
  localparam int NCPU_W        = 5;
  localparam int SLICE_W       = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;
  // holds a core count up to the largest supported core array
  localparam int CORE_LIM_W    = 7;

  localparam int MAX_CORES_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic [NCPU_W-1:0]  NUM_CPUS_RST   = NCPU_W'(16);
  localparam logic [SLICE_W-1:0] TIME_SLICE_RST = SLICE_W'(1000);

  typedef enum logic [2:0] {
    ACT_DISPATCH  = 3'd0,
    ACT_FINISH    = 3'd1,
    ACT_ENQUEUE   = 3'd2,
    ACT_INDEX_ERR = 3'd3,
    ACT_DROP      = 3'd4
  } action_e;

  typedef enum logic {
    OP_NEW  = 1'b0,
    OP_DONE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CPUS   = 1'b0,
    CFG_TIME_SLICE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_NEW  = 2'd0,
    CMD_DONE = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_e;

  typedef enum logic {
    ST_RUN  = 1'b0,
    ST_DISP = 1'b1
  } back_state_e;

  typedef struct packed {
    logic                  operation;
    logic [TAG_W-1:0]      job_tag;
    logic [CORE_IDX_W-1:0] core_index;
    logic                  work_left;
  } in_item_t;

  typedef struct packed {
    action_e             action;
    logic [TAG_W-1:0]    out_job_tag;
    logic [TCORE_W-1:0]  target_core;
    logic [SLICE_W-1:0]  slice_value;
    logic                last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [TAG_W-1:0]      tag;
    logic [CORE_IDX_W-1:0] core;
    logic                  left;
  } cmd_t;

endpackage

FILE: hdl/rrjd_front.sv
// Intake stage: accepts input transfers and classifies them into commands.
// Depends on rrjd_pkg.
`timescale 1ns / 1ps

module rrjd_front import rrjd_pkg::*; (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  input  logic [CORE_LIM_W-1:0] core_lim_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic bad_core;

  assign bad_core   = CORE_LIM_W'(in_item_i.core_index) >= core_lim_i;
  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    cmd_o.tag  = in_item_i.job_tag;
    cmd_o.core = in_item_i.core_index;
    cmd_o.left = in_item_i.work_left;
    if (op_e'(in_item_i.operation) == OP_NEW) begin
      cmd_o.kind = CMD_NEW;
    end else if (bad_core) begin
      cmd_o.kind = CMD_ERR;
    end else begin
      cmd_o.kind = CMD_DONE;
    end
  end

endmodule

FILE: hdl/rrjd_cmd_fifo.sv
// Two-entry command queue between intake and executor.
// Depends on rrjd_pkg.
`timescale 1ns / 1ps

module rrjd_cmd_fifo import rrjd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = ent_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: hdl/rrjd_back.sv
// Executor: idle map, ready-queue memory and pointers, output register.
// Depends on rrjd_pkg and round_robin_job_dispatcher_assert.svh.
`timescale 1ns / 1ps

`include "round_robin_job_dispatcher_assert.svh"

module rrjd_back import rrjd_pkg::*; #(
  parameter int MAX_CORES   = MAX_CORES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  logic [CORE_LIM_W-1:0] core_lim_i,
  input  logic [SLICE_W-1:0]    time_slice_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  back_state_e          state_q, state_d;
  logic [MAX_CORES-1:0] idle_q, idle_d;
  logic [QW-1:0]        head_q, head_d, tail_q, tail_d, head_inc, tail_inc;
  logic [CW-1:0]        count_q, count_d;
  logic [TAG_W-1:0]     mem [QUEUE_DEPTH];
  logic [TAG_W-1:0]     rd_q, byp_tag_q;
  logic                 byp_q, byp_d;
  logic [TCORE_W-1:0]   disp_core_q;
  logic                 out_valid_q, out_load;
  out_item_t            out_q, out_d;

  logic                 out_free, go, q_full, q_empty, mem_we, rd_en;
  logic                 found;
  logic [5:0]           sel_idx;
  logic [MAX_CORES-1:0] free_mask, done_mask;

  assign out_free    = !out_valid_q || out_ready_i;
  assign go          = (state_q == ST_RUN) && cmd_valid_i && out_free;
  assign cmd_pop_o   = go;
  assign q_full      = count_q == CW'(QUEUE_DEPTH);
  assign q_empty     = count_q == '0;
  assign head_inc    = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc    = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign rd_en       = go && (cmd_i.kind == CMD_DONE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // lowest idle core below the core limit
  always_comb begin
    found   = 1'b0;
    sel_idx = '0;
    for (int i = MAX_CORES - 1; i >= 0; i--) begin
      if (idle_q[i] && (CORE_LIM_W'(i) < core_lim_i)) begin
        found   = 1'b1;
        sel_idx = 6'(i);
      end
    end
    for (int i = 0; i < MAX_CORES; i++) begin
      free_mask[i] = sel_idx == 6'(i);
      done_mask[i] = CORE_LIM_W'(cmd_i.core) == CORE_LIM_W'(i);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (go && (cmd_i.kind == CMD_DONE) && (cmd_i.left || !q_empty)) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        if (out_free) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    idle_d   = idle_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    byp_d    = byp_q;
    mem_we   = 1'b0;
    out_load = 1'b0;
    out_d    = out_q;
    unique case (state_q)
      ST_RUN: begin
        if (go) begin
          out_load          = 1'b1;
          out_d.out_job_tag = cmd_i.tag;
          out_d.target_core = '0;
          out_d.slice_value = '0;
          out_d.last        = 1'b1;
          unique case (cmd_i.kind)
            CMD_NEW: begin
              if (found) begin
                idle_d            = idle_q & ~free_mask;
                out_d.action      = ACT_DISPATCH;
                out_d.target_core = TCORE_W'(sel_idx);
                out_d.slice_value = time_slice_i;
              end else if (!q_full) begin
                mem_we            = 1'b1;
                tail_d            = tail_inc;
                count_d           = count_q + 1'b1;
                out_d.action      = ACT_ENQUEUE;
                out_d.slice_value = time_slice_i;
              end else begin
                out_d.action = ACT_DROP;
              end
            end
            CMD_DONE: begin
              byp_d = 1'b0;
              if (cmd_i.left) begin
                // push the job, then pop the head for the freed core
                mem_we       = 1'b1;
                tail_d       = tail_inc;
                head_d       = head_inc;
                byp_d        = q_empty;
                idle_d       = idle_q & ~done_mask;
                out_d.action = ACT_ENQUEUE;
                out_d.last   = 1'b0;
              end else if (q_empty) begin
                idle_d       = idle_q | done_mask;
                out_d.action = ACT_FINISH;
              end else begin
                head_d       = head_inc;
                count_d      = count_q - 1'b1;
                idle_d       = idle_q & ~done_mask;
                out_d.action = ACT_FINISH;
                out_d.last   = 1'b0;
              end
            end
            CMD_ERR: begin
              out_d.action = ACT_INDEX_ERR;
            end
            default: begin
              out_d.action = ACT_INDEX_ERR;
            end
          endcase
        end
      end
      ST_DISP: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.action      = ACT_DISPATCH;
          out_d.out_job_tag = byp_q ? byp_tag_q : rd_q;
          out_d.target_core = disp_core_q;
          out_d.slice_value = '0;
          out_d.last        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      idle_q      <= '1;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idle_q      <= idle_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      byp_q       <= byp_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    if (go) begin
      byp_tag_q   <= cmd_i.tag;
      disp_core_q <= TCORE_W'(cmd_i.core);
    end
  end

  // read before write: a full-queue requeue pops the old head
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[head_q];
    end
    if (mem_we) begin
      mem[tail_q] <= cmd_i.tag;
    end
  end

  `RRJD_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "ready queue count overflow")
  `RRJD_ASSERT(a_ptr_match, !(q_empty || q_full) || (head_q == tail_q), "queue pointers diverge")
  `RRJD_ASSERT(a_disp_pending, !(state_q == ST_DISP && out_valid_q && out_q.last), "dispatch after last")
  `RRJD_ASSERT_NEXT(a_grab_core, go && cmd_i.kind == CMD_NEW && found, $countones(idle_q) == $countones($past(idle_q)) - 1, "dispatch did not take a core")

endmodule

FILE: hdl/round_robin_job_dispatcher.sv
// Channel     Direction  Payload     Handshake
// in          input      in_item_t   in_valid_i / in_ready_o
// out         output     out_item_t  out_valid_o / out_ready_i
// cfg         input      cfg_data_i  cfg_we_i with cfg_idx_i, no wait
// New job, index error or plain finish: run state only, next command taken
// when the output is free. Completion that dispatches from the ready queue:
// run state, then dispatch state, which sends the registered queue memory read.
// A two-entry command queue lets intake continue while the output stalls.
// Reset: all cores idle, queue empty; the queue memory is never cleared.
// Top level: configuration registers, intake, command queue and executor.
// Depends on rrjd_pkg, rrjd_front, rrjd_cmd_fifo and rrjd_back.
`timescale 1ns / 1ps

module round_robin_job_dispatcher import rrjd_pkg::*; #(
  parameter int MAX_CORES   = MAX_CORES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [NCPU_W-1:0]     num_cpus_q;
  logic [SLICE_W-1:0]    time_slice_q;
  logic [CORE_LIM_W-1:0] core_lim;
  logic                  fifo_full, fifo_push, fifo_pop, fifo_valid;
  cmd_t                  front_cmd, fifo_cmd;

  assign core_lim = (CORE_LIM_W'(num_cpus_q) > CORE_LIM_W'(MAX_CORES))
                  ? CORE_LIM_W'(MAX_CORES) : CORE_LIM_W'(num_cpus_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cpus_q   <= NUM_CPUS_RST;
      time_slice_q <= TIME_SLICE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_NUM_CPUS:   num_cpus_q   <= cfg_data_i[NCPU_W-1:0];
        CFG_TIME_SLICE: time_slice_q <= cfg_data_i[SLICE_W-1:0];
        default: ;
      endcase
    end
  end

  rrjd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .core_lim_i  (core_lim),
    .fifo_full_i (fifo_full),
    .push_o      (fifo_push),
    .cmd_o       (front_cmd)
  );

  rrjd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .cmd_o   (fifo_cmd)
  );

  rrjd_back #(
    .MAX_CORES   (MAX_CORES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (fifo_valid),
    .cmd_i        (fifo_cmd),
    .cmd_pop_o    (fifo_pop),
    .core_lim_i   (core_lim),
    .time_slice_i (time_slice_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
